// ----- sv/tip_pkg.sv -----
`default_nettype none

package tip_pkg;

    localparam int MAX_LENGTH_DEF = 4096;
    localparam int QUEUE_DEPTH    = 2;

    localparam int BASE_W   = 6;
    localparam int OFFSET_W = 13;
    localparam int VALUE_W  = 64;
    localparam int CODE_W   = 2;

    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
    localparam logic [BASE_W-1:0] BASE_BIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

    localparam logic [CODE_W-1:0] STOP_END          = 2'd0;
    localparam logic [CODE_W-1:0] STOP_INVALID_CHAR = 2'd1;
    localparam logic [CODE_W-1:0] STOP_INVALID_BASE = 2'd2;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        logic                is_nul;
        logic                is_blank;
        logic                is_minus;
        logic                is_zero;
        logic                is_b;
        logic                is_x;
        logic                is_alnum;
        logic [BASE_W-1:0]   digit;
        logic                first;
        logic [BASE_W-1:0]   base;
        logic [OFFSET_W-1:0] at;
        logic [OFFSET_W-1:0] next_at;
        logic                final_req;
    } tip_item_t;

endpackage

`default_nettype wire

// ----- sv/tip_front.sv -----
`default_nettype none

module tip_front
    import tip_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_character,
    input  wire logic              s_final_req,
    input  wire logic [BASE_W-1:0] number_base,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output tip_item_t              push_item
);

    localparam int POS_W = $clog2(MAX_LENGTH + 1);

    logic [POS_W-1:0]          pos_reg;
    logic [POS_W-1:0]          pos_next;
    logic [POS_W-1:0]          pos_inc;
    logic [POS_W+OFFSET_W-1:0] at_ext;
    logic [POS_W+OFFSET_W-1:0] next_ext;
    logic [7:0]                lower;
    logic                      is_num;
    logic                      is_letter;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    // Position saturates at the maximum length; offsets are reported modulo 2^13.
    assign pos_inc  = (pos_reg < POS_W'(MAX_LENGTH)) ? POS_W'(pos_reg + 1'b1) : pos_reg;
    assign at_ext   = {{OFFSET_W{1'b0}}, pos_reg};
    assign next_ext = {{OFFSET_W{1'b0}}, pos_inc};

    assign lower     = (s_character >= 8'd65 && s_character <= 8'd90) ?
                       8'(s_character + 8'd32) : s_character;
    assign is_num    = (s_character >= 8'd48 && s_character <= 8'd57);
    assign is_letter = (lower >= 8'd97 && lower <= 8'd122);

    always_comb begin
        push_item.is_nul    = (s_character == 8'd0);
        push_item.is_blank  = (s_character == 8'd32) || (s_character == 8'd12) ||
                              (s_character == 8'd10) || (s_character == 8'd13) ||
                              (s_character == 8'd9)  || (s_character == 8'd11);
        push_item.is_minus  = (s_character == 8'd45);
        push_item.is_zero   = (s_character == 8'd48);
        push_item.is_b      = (lower == 8'd98);
        push_item.is_x      = (lower == 8'd120);
        push_item.is_alnum  = is_num || is_letter;
        if (is_num) begin
            push_item.digit = BASE_W'(s_character - 8'd48);
        end else begin
            push_item.digit = BASE_W'(lower - 8'd87);
        end
        push_item.first     = (pos_reg == '0);
        push_item.base      = number_base;
        push_item.at        = at_ext[OFFSET_W-1:0];
        push_item.next_at   = next_ext[OFFSET_W-1:0];
        push_item.final_req = s_final_req;
    end

    always_comb begin
        pos_next = pos_reg;
        if (s_valid && s_ready) begin
            pos_next = s_final_req ? '0 : pos_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tip_queue.sv -----
`default_nettype none

module tip_queue
    import tip_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  tip_item_t  push_item,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output tip_item_t  pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tip_item_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tip_back.sv -----
`default_nettype none

module tip_back
    import tip_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  tip_item_t                 item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [VALUE_W-1:0]        m_value,
    output logic [OFFSET_W-1:0]       m_end_offset,
    output logic [CODE_W-1:0]         m_stop_code
);

    localparam logic [2:0] PH_LEAD      = 3'd0;
    localparam logic [2:0] PH_PREFIX    = 3'd1;
    localparam logic [2:0] PH_ZERO_AUTO = 3'd2;
    localparam logic [2:0] PH_ZERO_HEX  = 3'd3;
    localparam logic [2:0] PH_DIGITS    = 3'd4;
    localparam logic [2:0] PH_DONE      = 3'd5;

    logic [2:0]          phase_reg, phase_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [OFFSET_W-1:0] stop_off_reg, stop_off_next;
    logic [CODE_W-1:0]   code_reg, code_next;

    logic                m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]  m_acc_reg;
    logic                m_neg_reg;
    logic [OFFSET_W-1:0] m_off_reg;
    logic [CODE_W-1:0]   m_code_reg;

    logic                take;
    logic                start;
    logic                do_digit;
    logic [VALUE_W-1:0]  product;

    // A closing character needs the result register free; others never wait.
    assign item_ready = !item.final_req || !m_valid_reg || m_ready;
    assign take       = item_valid && item_ready;

    always_comb begin
        phase_next    = phase_reg;
        base_next     = item.first ? item.base : base_reg;
        neg_next      = neg_reg;
        stop_off_next = stop_off_reg;
        code_next     = code_reg;
        acc_next      = acc_reg;
        start         = 1'b0;
        do_digit      = 1'b0;
        product       = '0;

        if (item.first && (item.base == BASE_ONE || item.base > BASE_MAX)) begin
            phase_next    = PH_DONE;
            stop_off_next = '0;
            code_next     = STOP_INVALID_BASE;
        end

        unique case (phase_next)
            PH_LEAD: begin
                if (item.is_nul) begin
                    do_digit = 1'b1;
                end else if (item.is_blank) begin
                    do_digit = 1'b0;
                end else if (item.is_minus) begin
                    neg_next   = 1'b1;
                    phase_next = PH_PREFIX;
                end else begin
                    start = 1'b1;
                end
            end
            PH_PREFIX: begin
                start = 1'b1;
            end
            PH_ZERO_AUTO: begin
                phase_next = PH_DIGITS;
                if (item.is_b) begin
                    base_next = BASE_BIN;
                end else if (item.is_x) begin
                    base_next = BASE_HEX;
                end else begin
                    base_next = BASE_OCT;
                    do_digit  = 1'b1;
                end
            end
            PH_ZERO_HEX: begin
                phase_next = PH_DIGITS;
                do_digit   = !item.is_x;
            end
            PH_DIGITS: begin
                do_digit = 1'b1;
            end
            default: begin
                do_digit = 1'b0;
            end
        endcase

        if (start) begin
            if (base_next == BASE_AUTO && item.is_zero) begin
                phase_next = PH_ZERO_AUTO;
            end else if (base_next == BASE_HEX && item.is_zero) begin
                phase_next = PH_ZERO_HEX;
            end else begin
                if (base_next == BASE_AUTO) begin
                    base_next = BASE_DEC;
                end
                phase_next = PH_DIGITS;
                do_digit   = 1'b1;
            end
        end

        product = acc_reg * {{(VALUE_W-BASE_W){1'b0}}, base_next};

        if (do_digit) begin
            if (item.is_nul) begin
                phase_next    = PH_DONE;
                stop_off_next = item.at;
                code_next     = STOP_END;
            end else if (item.is_blank) begin
                acc_next = acc_reg;
            end else if (!item.is_alnum || item.digit >= base_next) begin
                phase_next    = PH_DONE;
                stop_off_next = item.at;
                code_next     = STOP_INVALID_CHAR;
            end else begin
                acc_next = product + {{(VALUE_W-BASE_W){1'b0}}, item.digit};
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (take && item.final_req) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_LEAD;
            acc_reg      <= '0;
            neg_reg      <= 1'b0;
            base_reg     <= '0;
            stop_off_reg <= '0;
            code_reg     <= STOP_END;
            m_valid_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (take) begin
                if (item.final_req) begin
                    phase_reg    <= PH_LEAD;
                    acc_reg      <= '0;
                    neg_reg      <= 1'b0;
                    base_reg     <= '0;
                    stop_off_reg <= '0;
                    code_reg     <= STOP_END;
                end else begin
                    phase_reg    <= phase_next;
                    acc_reg      <= acc_next;
                    neg_reg      <= neg_next;
                    base_reg     <= base_next;
                    stop_off_reg <= stop_off_next;
                    code_reg     <= code_next;
                end
            end
        end
    end

    // A string closed without a stop ends just after its last character.
    always_ff @(posedge aclk) begin
        if (take && item.final_req) begin
            m_acc_reg <= acc_next;
            m_neg_reg <= neg_next;
            if (phase_next == PH_DONE) begin
                m_off_reg  <= stop_off_next;
                m_code_reg <= code_next;
            end else begin
                m_off_reg  <= item.next_at;
                m_code_reg <= STOP_END;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_neg_reg ? VALUE_W'(~m_acc_reg + 1'b1) : m_acc_reg;
    assign m_end_offset = m_off_reg;
    assign m_stop_code  = m_code_reg;

endmodule

`default_nettype wire

// ----- sv/text_to_integer_parser_core.sv -----
`default_nettype none

// Streaming string-to-integer parser. Each s_ transfer carries one character;
// the transfer with s_final_req high closes the string and yields exactly one
// m_ result (value, end offset, stop code). The block takes one character
// every cycle unless the back holds a closing character for a busy result
// register: the front classifies the byte and stamps its offset, a two-entry
// queue decouples it from the back, and the back does one 64-bit by 6-bit
// multiply-add per cycle, which sets the clock. m_valid is registered when the
// back takes the closing character; the result is held in an output register,
// so the next string streams up to its last character while the result waits.
// The cfg_number_base radix is sampled on each string's first character.

module text_to_integer_parser_core
    import tip_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [BASE_W-1:0]   cfg_number_base,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_character,
    input  wire logic                s_final_req,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [VALUE_W-1:0]       m_value,
    output logic [OFFSET_W-1:0]      m_end_offset,
    output logic [CODE_W-1:0]        m_stop_code
);

    logic [BASE_W-1:0] base_reg;
    logic              push_valid;
    logic              push_ready;
    tip_item_t         push_item;
    logic              pop_valid;
    logic              pop_ready;
    tip_item_t         pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            base_reg <= cfg_number_base;
        end
    end

    tip_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .s_final_req (s_final_req),
        .number_base (base_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    tip_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    tip_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (pop_valid),
        .item_ready   (pop_ready),
        .item         (pop_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_end_offset (m_end_offset),
        .m_stop_code  (m_stop_code)
    );

    // A bad radix stops before any digit is taken.
    a_bad_base_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stop_code == STOP_INVALID_BASE) |->
            (m_end_offset == '0 && m_value == '0))
        else $error("invalid base result carries a value or offset");

    // Stopping at the very first character leaves nothing accumulated.
    a_offset_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (MAX_LENGTH < 8192 && m_valid && m_end_offset == '0) |-> (m_value == '0))
        else $error("result stopped at offset zero with a nonzero value");

endmodule

`default_nettype wire
